// ----- hdl/urav_pkg.sv -----
// ----------------------------------------------------------------------------
// urav_pkg
// Shared widths, register map and reset values of the echo range averager.
// ----------------------------------------------------------------------------
package urav_pkg;

   localparam int ECHO_BITS    = 14;
   localparam int DIST_BITS    = 17;
   localparam int SUM_BITS     = 21;
   localparam int CNT_BITS     = 5;
   localparam int MIND_BITS    = 16;
   localparam int SCALE_BITS   = 11;
   localparam int PROD_BITS    = ECHO_BITS + SCALE_BITS;
   localparam int FRAC_BITS    = 8;
   localparam int MUL_CNT_BITS = $clog2(ECHO_BITS);
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
   localparam int ADDR_BITS    = 4;
   localparam int DATA_BITS    = 32;

   localparam logic [SCALE_BITS-1:0] SCALE_Q8     = 11'd1124;
   localparam logic [CNT_BITS-1:0]   MAX_ATTEMPTS = 5'd16;

   localparam logic [ECHO_BITS-1:0] TIMEOUT_RESET = 14'd12000;
   localparam logic [MIND_BITS-1:0] MIND_RESET    = 16'd256;
   localparam logic [CNT_BITS-1:0]  APW_RESET     = 5'd10;

   typedef enum logic [1:0] {
      REG_TIMEOUT = 2'd0,
      REG_MIN_DIST = 2'd1,
      REG_ATTEMPTS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hdl/urav_req_if.sv -----
// ----------------------------------------------------------------------------
// urav_req_if
// Request channel: one echo width per request.
// ----------------------------------------------------------------------------
interface urav_req_if;
   logic                           valid;
   logic                           ready;
   logic [urav_pkg::ECHO_BITS-1:0] echo_us;

   modport source (output valid, output echo_us, input ready);
   modport sink (input valid, input echo_us, output ready);
endinterface

// ----- hdl/urav_rsp_if.sv -----
// ----------------------------------------------------------------------------
// urav_rsp_if
// Response channel: one window summary per response.
// ----------------------------------------------------------------------------
interface urav_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           range_valid;
   logic [urav_pkg::CNT_BITS-1:0]  accepted_count;
   logic [urav_pkg::DIST_BITS-1:0] avg_distance_q8;
   logic [urav_pkg::DIST_BITS-1:0] min_distance_seen_q8;
   logic [urav_pkg::DIST_BITS-1:0] max_distance_seen_q8;

   modport source (output valid, output range_valid, output accepted_count,
                   output avg_distance_q8, output min_distance_seen_q8,
                   output max_distance_seen_q8, input ready);
   modport sink (input valid, input range_valid, input accepted_count,
                 input avg_distance_q8, input min_distance_seen_q8,
                 input max_distance_seen_q8, output ready);
endinterface

// ----- hdl/ultrasonic_echo_range_averager.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_averager: windowed echo range statistics.
// Ready is low while a request runs the serial multiply in S_MUL and one update in S_EVAL.
// A closing request waits in S_CLOSE on a pending response; a nonempty window then uses S_DIV.
// Synchronous reset restores register defaults and empties the window.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_averager (
   input  logic                           clock,
   input  logic                           reset,
   urav_req_if.sink                       req_ch,
   urav_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [urav_pkg::ADDR_BITS-1:0] paddr,
   input  logic [urav_pkg::DATA_BITS-1:0] pwdata,
   output logic [urav_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_EVAL,
      S_CLOSE,
      S_DIV
   } state_type;

   state_type                         state_ff, state_in;
   logic [urav_pkg::ECHO_BITS-1:0]    timeout_ff, timeout_in;
   logic [urav_pkg::MIND_BITS-1:0]    mind_ff, mind_in;
   logic [urav_pkg::CNT_BITS-1:0]     apw_ff, apw_in;
   logic [urav_pkg::PROD_BITS-1:0]    prod_ff, prod_in;
   logic [urav_pkg::MUL_CNT_BITS-1:0] mcnt_ff, mcnt_in;
   logic                              ok_ff, ok_in;
   logic [urav_pkg::CNT_BITS-1:0]     attempt_ff, attempt_in;
   logic [urav_pkg::CNT_BITS-1:0]     good_ff, good_in;
   logic [urav_pkg::SUM_BITS-1:0]     sum_ff, sum_in;
   logic [urav_pkg::DIST_BITS-1:0]    min_ff, min_in;
   logic [urav_pkg::DIST_BITS-1:0]    max_ff, max_in;
   logic                              rvalid_ff, rvalid_in;
   logic                              rrange_ff, rrange_in;
   logic [urav_pkg::CNT_BITS-1:0]     rcnt_ff, rcnt_in;
   logic [urav_pkg::DIST_BITS-1:0]    ravg_ff, ravg_in;
   logic [urav_pkg::DIST_BITS-1:0]    rmin_ff, rmin_in;
   logic [urav_pkg::DIST_BITS-1:0]    rmax_ff, rmax_in;

   logic                                  wr_en;
   logic [urav_pkg::PROD_BITS-urav_pkg::ECHO_BITS:0] mul_sum;
   logic [urav_pkg::DIST_BITS-1:0]        dist_q8;
   logic                                  take;
   logic [urav_pkg::SUM_BITS:0]           sum_add;
   logic [urav_pkg::CNT_BITS-1:0]         win_len;
   logic [urav_pkg::CNT_BITS-1:0]         attempt_nx;
   logic                                  div_start;
   urav_pkg::div_stat_type                div_stat;
   logic [urav_pkg::SUM_BITS-1:0]         div_quo;

   urav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (good_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         urav_pkg::REG_TIMEOUT:  prdata = urav_pkg::DATA_BITS'(timeout_ff);
         urav_pkg::REG_MIN_DIST: prdata = urav_pkg::DATA_BITS'(mind_ff);
         urav_pkg::REG_ATTEMPTS: prdata = urav_pkg::DATA_BITS'(apw_ff);
         default:                prdata = '0;
      endcase
   end

   always_comb begin
      mul_sum = {1'b0, prod_ff[urav_pkg::PROD_BITS-1:urav_pkg::ECHO_BITS]}
              + (prod_ff[0] ? {1'b0, urav_pkg::SCALE_Q8} : '0);
      dist_q8 = prod_ff[urav_pkg::PROD_BITS-1:urav_pkg::FRAC_BITS];
      take    = ok_ff && (dist_q8 >= urav_pkg::DIST_BITS'(mind_ff));
      sum_add = {1'b0, sum_ff} + (urav_pkg::SUM_BITS + 1)'(dist_q8);
      if (apw_ff == '0) begin
         win_len = urav_pkg::CNT_BITS'(1);
      end else if (apw_ff > urav_pkg::MAX_ATTEMPTS) begin
         win_len = urav_pkg::MAX_ATTEMPTS;
      end else begin
         win_len = apw_ff;
      end
      attempt_nx = attempt_ff + 1'b1;
      div_start  = (state_ff == S_CLOSE) && !rvalid_ff && (good_ff != '0);
   end

   always_comb begin
      state_in   = state_ff;
      timeout_in = timeout_ff;
      mind_in    = mind_ff;
      apw_in     = apw_ff;
      prod_in    = prod_ff;
      mcnt_in    = mcnt_ff;
      ok_in      = ok_ff;
      attempt_in = attempt_ff;
      good_in    = good_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      rvalid_in  = rvalid_ff;
      rrange_in  = rrange_ff;
      rcnt_in    = rcnt_ff;
      ravg_in    = ravg_ff;
      rmin_in    = rmin_ff;
      rmax_in    = rmax_ff;

      if (wr_en) begin
         case (paddr[3:2])
            urav_pkg::REG_TIMEOUT:  timeout_in = pwdata[urav_pkg::ECHO_BITS-1:0];
            urav_pkg::REG_MIN_DIST: mind_in    = pwdata[urav_pkg::MIND_BITS-1:0];
            urav_pkg::REG_ATTEMPTS: apw_in     = pwdata[urav_pkg::CNT_BITS-1:0];
            default: ;
         endcase
      end

      if (rvalid_ff && rsp_ch.ready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               prod_in  = urav_pkg::PROD_BITS'(req_ch.echo_us);
               ok_in    = (req_ch.echo_us != '0) && (req_ch.echo_us <= timeout_ff);
               mcnt_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = {mul_sum, prod_ff[urav_pkg::ECHO_BITS-1:1]};
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == urav_pkg::MUL_CNT_BITS'(urav_pkg::ECHO_BITS - 1)) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (take) begin
               good_in = good_ff + 1'b1;
               if (good_ff == '0) begin
                  min_in = dist_q8;
                  max_in = dist_q8;
                  sum_in = urav_pkg::SUM_BITS'(dist_q8);
               end else begin
                  if (dist_q8 < min_ff) min_in = dist_q8;
                  if (dist_q8 > max_ff) max_in = dist_q8;
                  sum_in = sum_add[urav_pkg::SUM_BITS] ? '1
                                                       : sum_add[urav_pkg::SUM_BITS-1:0];
               end
            end
            attempt_in = attempt_nx;
            state_in   = (attempt_nx >= win_len) ? S_CLOSE : S_IDLE;
         end
         S_CLOSE: begin
            if (!rvalid_ff) begin
               rrange_in  = good_ff != '0;
               rcnt_in    = good_ff;
               rmin_in    = min_ff;
               rmax_in    = max_ff;
               ravg_in    = '0;
               attempt_in = '0;
               good_in    = '0;
               sum_in     = '0;
               min_in     = '0;
               max_in     = '0;
               if (good_ff != '0) begin
                  state_in = S_DIV;
               end else begin
                  rvalid_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               ravg_in   = div_quo[urav_pkg::DIST_BITS-1:0];
               rvalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         timeout_ff <= urav_pkg::TIMEOUT_RESET;
         mind_ff    <= urav_pkg::MIND_RESET;
         apw_ff     <= urav_pkg::APW_RESET;
         prod_ff    <= '0;
         mcnt_ff    <= '0;
         ok_ff      <= 1'b0;
         attempt_ff <= '0;
         good_ff    <= '0;
         sum_ff     <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         rvalid_ff  <= 1'b0;
         rrange_ff  <= 1'b0;
         rcnt_ff    <= '0;
         ravg_ff    <= '0;
         rmin_ff    <= '0;
         rmax_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         timeout_ff <= timeout_in;
         mind_ff    <= mind_in;
         apw_ff     <= apw_in;
         prod_ff    <= prod_in;
         mcnt_ff    <= mcnt_in;
         ok_ff      <= ok_in;
         attempt_ff <= attempt_in;
         good_ff    <= good_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         rvalid_ff  <= rvalid_in;
         rrange_ff  <= rrange_in;
         rcnt_ff    <= rcnt_in;
         ravg_ff    <= ravg_in;
         rmin_ff    <= rmin_in;
         rmax_ff    <= rmax_in;
      end
   end

   assign req_ch.ready                = state_ff == S_IDLE;
   assign rsp_ch.valid                = rvalid_ff;
   assign rsp_ch.range_valid          = rrange_ff;
   assign rsp_ch.accepted_count       = rcnt_ff;
   assign rsp_ch.avg_distance_q8      = ravg_ff;
   assign rsp_ch.min_distance_seen_q8 = rmin_ff;
   assign rsp_ch.max_distance_seen_q8 = rmax_ff;

endmodule

// ----- hdl/urav_div.sv -----
// ----------------------------------------------------------------------------
// urav_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module urav_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [urav_pkg::SUM_BITS-1:0] dividend,
   input  logic [urav_pkg::CNT_BITS-1:0] divisor,
   output urav_pkg::div_stat_type        stat,
   output logic [urav_pkg::SUM_BITS-1:0] quotient
);

   logic [urav_pkg::SUM_BITS-1:0]     quo_ff, quo_in;
   logic [urav_pkg::CNT_BITS-1:0]     rem_ff, rem_in;
   logic [urav_pkg::CNT_BITS-1:0]     dvs_ff, dvs_in;
   logic [urav_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [urav_pkg::CNT_BITS:0]       trial;
   logic [urav_pkg::CNT_BITS:0]       diff;
   logic                              fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[urav_pkg::SUM_BITS-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[urav_pkg::SUM_BITS-2:0], fits};
         rem_in = fits ? diff[urav_pkg::CNT_BITS-1:0] : trial[urav_pkg::CNT_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == urav_pkg::DIV_CNT_BITS'(urav_pkg::SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff  <= '0;
         rem_ff  <= '0;
         dvs_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         dvs_ff  <= dvs_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ----- hdl/urav_checker.sv -----
// ----------------------------------------------------------------------------
// urav_checker
// Port-level checks of the echo range averager, bound to the top level.
// ----------------------------------------------------------------------------
module urav_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           range_valid,
   input logic [urav_pkg::CNT_BITS-1:0]  accepted_count,
   input logic [urav_pkg::DIST_BITS-1:0] avg_q8,
   input logic [urav_pkg::DIST_BITS-1:0] min_q8,
   input logic [urav_pkg::DIST_BITS-1:0] max_q8,
   input logic                           pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !range_valid |->
         accepted_count == '0 && avg_q8 == '0 && min_q8 == '0 && max_q8 == '0)
      else $error("empty window response carries nonzero fields");

   a_avg_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && range_valid |-> min_q8 <= avg_q8 && avg_q8 <= max_q8)
      else $error("average outside min/max");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && range_valid |->
         accepted_count != '0 && accepted_count <= urav_pkg::MAX_ATTEMPTS)
      else $error("accepted count out of range");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind ultrasonic_echo_range_averager urav_checker u_urav_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .range_valid    (rsp_ch.range_valid),
   .accepted_count (rsp_ch.accepted_count),
   .avg_q8         (rsp_ch.avg_distance_q8),
   .min_q8         (rsp_ch.min_distance_seen_q8),
   .max_q8         (rsp_ch.max_distance_seen_q8),
   .pready         (pready)
);
